/* rtl/ogrs_pkg.sv */
// package for the occupancy grid ray sensor: field widths, ray codes and the
// quarter-wave sine table used for ray directions
// no dependencies
`default_nettype none

package ogrs_pkg;

  localparam int MAP_SIDE_DEF        = 256;
  localparam int PIXELS_PER_WORD_DEF = 64;

  localparam int RAY_COUNT = 5;
  localparam int DIR_W     = 3;
  localparam int DIST_W    = 8;
  localparam int STEP_W    = DIST_W + 1;
  // q.14 point width: position*64 plus 255 steps of a unit vector, with sign
  localparam int ACC_W     = 25;
  localparam int TRIG_W    = 16;
  localparam int Q88_W     = 16;
  localparam int ANG_W     = 10;

  localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 8'd100;

  localparam logic [ANG_W-1:0] ANGLE_45 = 10'd128;
  localparam logic [ANG_W-1:0] ANGLE_90 = 10'd256;

  localparam logic [DIR_W-1:0] DIR_FRONT      = 3'd0;
  localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT_DIAG  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT_DIAG = 3'd4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SENSE = 1'b1;

  typedef logic [14:0] sine_tab_t [256];
  typedef longint unsigned den_t [10];

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam den_t SERIES_DEN = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                  64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  // round(16384*sin(pi*idx/512)), taylor series in q30, elaboration only
  function automatic logic [14:0] quarter_sine(int unsigned idx);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x    = (PI_Q30 * longint'(idx) + 64'd256) >> 9;
    x2   = (x * x) >> 30;
    term = x;
    sum  = 0;
    for (int i = 0; i < 10; i++) begin
      if (i % 2 == 0) sum = sum + longint'(term);
      else            sum = sum - longint'(term);
      term = ((term * x2) >> 30) / SERIES_DEN[i];
    end
    if (sum < 0) sum = 0;
    sum = (sum + 32768) >>> 16;
    if (sum > 16384) sum = 16384;
    return sum[14:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = quarter_sine(i);
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // q1.14 sine of a 10-bit angle code
  function automatic logic signed [TRIG_W-1:0] sine_q14(logic [ANG_W-1:0] a);
    logic [8:0]  idx;
    logic [14:0] v;
    idx = a[8] ? (9'd256 - {1'b0, a[7:0]}) : {1'b0, a[7:0]};
    v   = idx[8] ? 15'd16384 : SINE_TAB[idx[7:0]];
    return a[9] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  function automatic logic [ANG_W-1:0] ray_offset(logic [DIR_W-1:0] d);
    case (d)
      DIR_FRONT:      return '0;
      DIR_LEFT:       return -ANGLE_90;
      DIR_RIGHT:      return ANGLE_90;
      DIR_LEFT_DIAG:  return -ANGLE_45;
      DIR_RIGHT_DIAG: return ANGLE_45;
      default:        return '0;
    endcase
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SETUP  = 4'b0010,
    ST_MARCH  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

endpackage

`default_nettype wire

/* rtl/occupancy_grid_ray_sensor.sv */
// occupancy grid ray sensor top level: map memory, ray march sequencer,
// result register; depends on ogrs_pkg
// sense: a sense transaction gives five results; each ray goes through setup,
//   up to max_distance + 1 map reads, the check of the last read and result,
//   and a result can stall until the output is free
// throughput: one item at a time; a load is written through the single map
//   write port; the ray loop is bound by the one map read per cycle
// reset: control state, max_distance (100) and the stored hit points clear at
//   once; the map holds nothing until loaded and needs no clearing pass
`default_nettype none

module occupancy_grid_ray_sensor import ogrs_pkg::*; #(
  // both must be powers of two
  parameter int MAP_SIDE        = MAP_SIDE_DEF,
  parameter int PIXELS_PER_WORD = PIXELS_PER_WORD_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // map_row[7:0] map_word[9:8] map_bits[73:10] pos_x[89:74] pos_y[105:90]
  // heading[115:106], zero fill
  input  wire logic [119:0] s_tdata,
  // func[0]
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // hit_x[15:0] hit_y[31:16] found[32] collided[33], zero fill
  output logic [39:0]       m_tdata,
  // direction[2:0]
  output logic [2:0]        m_tuser,
  output logic              m_tlast,
  input  wire logic         cfg_we,
  input  wire logic [7:0]   cfg_data
);

  localparam int WORDS_PER_ROW = MAP_SIDE / PIXELS_PER_WORD;
  localparam int MAP_WORDS     = MAP_SIDE * WORDS_PER_ROW;
  localparam int ADDR_W        = $clog2(MAP_WORDS);
  localparam int PIX_W         = $clog2(MAP_SIDE);
  localparam int BIT_W         = $clog2(PIXELS_PER_WORD);
  localparam int HI_W          = ACC_W - 15;

  // input field unpacking
  logic              in_func;
  logic [7:0]        in_row;
  logic [1:0]        in_word;
  logic [63:0]       in_bits;
  logic [15:0]       in_pos_x;
  logic [15:0]       in_pos_y;
  logic [ANG_W-1:0]  in_heading;

  assign in_func    = s_tuser[0];
  assign in_row     = s_tdata[7:0];
  assign in_word    = s_tdata[9:8];
  assign in_bits    = s_tdata[73:10];
  assign in_pos_x   = s_tdata[89:74];
  assign in_pos_y   = s_tdata[105:90];
  assign in_heading = s_tdata[115:106];

  state_t state;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // config register
  logic [DIST_W-1:0] max_distance;
  always_ff @(posedge clk) begin
    if (rst) max_distance <= MAX_DISTANCE_RESET;
    else if (cfg_we) max_distance <= cfg_data;
  end

  // sense context
  logic signed [ACC_W-1:0] base_x, base_y;
  logic [ANG_W-1:0]        heading;
  logic [DIR_W-1:0]        ray;
  logic                    collided;

  // per-ray march state
  logic signed [TRIG_W-1:0] cx, cy;
  logic signed [ACC_W-1:0]  acc_x, acc_y;
  logic [STEP_W-1:0]        k_iss;
  logic                     issuing;

  // check stage of the read pipeline
  logic                    s1_v, s1_out, s1_last, s1_first;
  logic [BIT_W-1:0]        s1_bit;
  logic signed [ACC_W-1:0] s1_px, s1_py;

  logic [31:0] last_hit [RAY_COUNT];

  // map memory
  logic [PIXELS_PER_WORD-1:0] mem [MAP_WORDS];
  logic [PIXELS_PER_WORD-1:0] mem_q;
  logic [ADDR_W-1:0]          rd_addr, wr_addr;
  logic                       wr_en;

  assign wr_addr = ADDR_W'(32'(in_row) * WORDS_PER_ROW + 32'(in_word));
  assign wr_en   = accept && (in_func == FUNC_LOAD) && (32'(in_row) < MAP_SIDE)
                   && (32'(in_word) < WORDS_PER_ROW);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_bits[PIXELS_PER_WORD-1:0];
    mem_q <= mem[rd_addr];
  end

  // pixel decode of the point being issued
  logic [HI_W-1:0]  hi_x, hi_y;
  logic             iss_out;
  logic [PIX_W-1:0] pix_x, pix_y;

  assign hi_x    = acc_x[ACC_W-2:14];
  assign hi_y    = acc_y[ACC_W-2:14];
  assign iss_out = acc_x[ACC_W-1] || acc_y[ACC_W-1] ||
                   (32'(hi_x) >= MAP_SIDE) || (32'(hi_y) >= MAP_SIDE);
  assign pix_x   = hi_x[PIX_W-1:0];
  assign pix_y   = hi_y[PIX_W-1:0];

  // word address is row * words_per_row + x / pixels_per_word
  assign rd_addr = ADDR_W'(32'(pix_y) * WORDS_PER_ROW + 32'(pix_x >> BIT_W));

  // hit test of the checked point
  logic hit;
  assign hit = s1_v && (s1_out || mem_q[s1_bit]);

  function automatic logic [Q88_W-1:0] to_q88(logic signed [ACC_W-1:0] p);
    logic [ACC_W-7:0] v;
    v = p[ACC_W-1:6];
    if (p[ACC_W-1]) return '0;
    if (v > (ACC_W-6)'(16'hffff)) return 16'hffff;
    return v[Q88_W-1:0];
  endfunction

  logic [ANG_W-1:0] ray_ang;
  assign ray_ang = heading + ray_offset(ray);

  logic found;
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ray      <= '0;
      s1_v     <= 1'b0;
      issuing  <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < RAY_COUNT; i++) last_hit[i] <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && in_func == FUNC_SENSE) begin
            base_x  <= ACC_W'({in_pos_x, 6'b0});
            base_y  <= ACC_W'({in_pos_y, 6'b0});
            heading <= in_heading;
            ray     <= DIR_FRONT;
            state   <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          // cosine is the sine a quarter turn ahead
          cx      <= sine_q14(ray_ang + ANGLE_90);
          cy      <= sine_q14(ray_ang);
          acc_x   <= base_x;
          acc_y   <= base_y;
          k_iss   <= '0;
          issuing <= 1'b1;
          s1_v    <= 1'b0;
          found   <= 1'b0;
          state   <= ST_MARCH;
        end
        ST_MARCH: begin
          // issue the next step while the previous one is checked
          s1_v <= issuing;
          if (issuing) begin
            s1_out   <= iss_out;
            s1_bit   <= pix_x[BIT_W-1:0];
            s1_px    <= acc_x;
            s1_py    <= acc_y;
            s1_first <= (k_iss == '0);
            s1_last  <= (k_iss == STEP_W'(max_distance));
            issuing  <= (k_iss != STEP_W'(max_distance));
            acc_x    <= acc_x + ACC_W'(cx);
            acc_y    <= acc_y + ACC_W'(cy);
            k_iss    <= k_iss + 1'b1;
          end
          if (s1_v && s1_first && ray == DIR_FRONT) collided <= hit;
          if (hit) begin
            last_hit[ray] <= {to_q88(s1_py), to_q88(s1_px)};
            found         <= 1'b1;
            issuing       <= 1'b0;
            state         <= ST_RESULT;
          end else if (s1_v && s1_last) begin
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          s1_v <= 1'b0;
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, collided, found, last_hit[ray]};
            m_tuser  <= ray;
            m_tlast  <= (ray == DIR_RIGHT_DIAG);
            if (ray == DIR_RIGHT_DIAG) begin
              state <= ST_IDLE;
            end else begin
              ray   <= ray + 1'b1;
              state <= ST_SETUP;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_last_on_final_ray: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser == DIR_RIGHT_DIAG)))
    else $error("tlast not on final ray");
  a_setup_to_march: assert property (@(posedge clk) disable iff (rst)
    state == ST_SETUP |=> state == ST_MARCH)
    else $error("setup did not start march");
  a_result_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && out_free) |=> m_tvalid)
    else $error("result not presented");
  a_ray_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> ray <= DIR_RIGHT_DIAG)
    else $error("ray index out of range");
`endif

endmodule

`default_nettype wire
